### rtl/binary_to_decimal_ascii_top_macros.svh
// Assertion macros for the checker file of the decimal converter.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bda_pkg.sv
// Types and constants shared by the decimal converter modules.
package bda_pkg;

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic conv;
    logic skip;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic conv_last;
    logic top_zero;
    logic one_left;
    logic out_free;
  } sts_t;

endpackage

### rtl/bda_ctrl.sv
// Controller state machine of the decimal converter.
module bda_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bda_pkg::sts_t sts_i,
  output bda_pkg::cmd_t cmd_o
);

  bda_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      bda_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bda_pkg::ST_CONV;
        end
      end
      bda_pkg::ST_CONV: begin
        cmd_o.conv = 1'b1;
        if (sts_i.conv_last) begin
          state_d = bda_pkg::ST_SKIP;
        end
      end
      bda_pkg::ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if (sts_i.top_zero && !sts_i.one_left) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = bda_pkg::ST_EMIT;
        end
      end
      bda_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.one_left) begin
            state_d = bda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = bda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/bda_datapath.sv
// Shift-add-3 datapath, digit shifter and output register of the decimal converter.
module bda_datapath #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bda_pkg::cmd_t         cmd_i,
  output bda_pkg::sts_t         sts_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [5:0]            digit_char_o,
  output logic [3:0]            digit_count_o,
  output logic                  last_o
);

  localparam int unsigned DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int unsigned BCD_W  = DIGITS * 4;
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS);
  localparam int unsigned DW     = $clog2(DIGITS + 1);

  logic [VALUE_BITS-1:0] bin_q;
  logic [BCD_W-1:0]      bcd_q;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      bit_cnt_q;
  logic [DW-1:0]         tot_q;
  logic [DW-1:0]         rem_q;
  logic [3:0]            top_dig;
  logic                  out_valid_q;
  logic [5:0]            char_q;
  logic [3:0]            count_q;
  logic                  last_q;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    logic [3:0] dig;
    dig = '0;
    adj = '0;
    for (int i = 0; i < DIGITS; i++) begin
      dig            = bcd_q[i*4 +: 4];
      adj[i*4 +: 4]  = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  assign top_dig = bcd_q[BCD_W-1 -: 4];

  assign sts_o.conv_last = (bit_cnt_q == '0);
  assign sts_o.top_zero  = (top_dig == 4'd0);
  assign sts_o.one_left  = (rem_q == DW'(1));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_cnt_q   <= '0;
      tot_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        bit_cnt_q <= CNT_W'(VALUE_BITS - 1);
        tot_q     <= DW'(DIGITS);
        rem_q     <= DW'(DIGITS);
      end else if (cmd_i.conv) begin
        bit_cnt_q <= bit_cnt_q - CNT_W'(1);
      end else if (cmd_i.skip) begin
        tot_q <= tot_q - DW'(1);
        rem_q <= rem_q - DW'(1);
      end else if (cmd_i.emit) begin
        rem_q <= rem_q - DW'(1);
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (cmd_i.conv) begin
      bcd_q <= {adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
    end else if (cmd_i.skip || cmd_i.emit) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'b0000};
    end
    if (cmd_i.emit) begin
      char_q  <= bda_pkg::ASCII_ZERO + {2'b00, top_dig};
      count_q <= 4'(tot_q);
      last_q  <= (rem_q == DW'(1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digit_char_o  = char_q;
  assign digit_count_o = count_q;
  assign last_o        = last_q;

endmodule

### rtl/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o   | value_i
//   out     | output    | out_valid_o / out_stall_i | digit_char_o, digit_count_o, last_o
//
// One item passes through a load, one shift-add-3 step per input bit, the drop
// of up to DIGITS-1 leading zero digits, a step that leaves the zero drop, then
// the emission of its digits one at a time, each waiting for a free output.
// The shift-add-3 register pass takes one input bit per cycle.
// Reset (rst_ni low, asynchronous) returns the controller to idle, clears the
// counters and empties the output register; the data registers are not reset.
// A stalled output register holds its digit and the controller waits; the
// next item is taken once the last digit of the run sits in the output register.
module binary_to_decimal_ascii_top #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [5:0]            digit_char_o,
  output logic [3:0]            digit_count_o,
  output logic                  last_o
);

  // command and status between controller and datapath
  bda_pkg::cmd_t cmd;
  bda_pkg::sts_t sts;

  // sequence load, conversion, zero skipping and digit emission
  bda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // hold the binary and BCD registers, the digit counts and the output register
  bda_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .value_i       (value_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .digit_char_o  (digit_char_o),
    .digit_count_o (digit_count_o),
    .last_o        (last_o)
  );

endmodule

### rtl/bda_checker.sv
// Port-level assertions of the decimal converter and their bind.
`include "binary_to_decimal_ascii_top_macros.svh"

module bda_checker #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] digit_char_o,
  input logic [3:0] digit_count_o,
  input logic       last_o
);

  logic        out_held;
  logic [11:0] out_word;
  logic        char_ok;
  logic        in_acc;
  logic        one_digit;

  assign out_held  = out_valid_o && out_stall_i;
  assign out_word  = {out_valid_o, digit_char_o, digit_count_o, last_o};
  assign char_ok   = (digit_char_o >= bda_pkg::ASCII_ZERO) &&
                     (digit_char_o <= bda_pkg::ASCII_ZERO + 6'd9);
  assign in_acc    = in_valid_i && !in_stall_o;
  // wider values can wrap the 4-bit count back to one
  assign one_digit = (VALUE_BITS <= 32) && out_valid_o && (digit_count_o == 4'd1);

  `BDA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, $stable(out_word), "result moved")
  `BDA_ASSERT_IMP(a_char_range, clk_i, rst_ni, out_valid_o, char_ok, "digit out of range")
  `BDA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o, "not busy")
  `BDA_ASSERT_IMP(a_single_digit_last, clk_i, rst_ni, one_digit, last_o, "one digit not last")

endmodule

bind binary_to_decimal_ascii_top bda_checker #(.VALUE_BITS(VALUE_BITS)) u_bda_checker (.*);
